@@ hw/rtl/ppte_pkg.sv @@
// Shared types, codes and constant tables for the piecewise polynomial trajectory evaluator.
// Depends on nothing; every other file imports it.
`default_nettype none
package ppte_pkg;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_COMMIT = 2'd2;
   localparam logic [1:0] ACT_EVAL   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic CSR_DEGREE = 1'b0;
   localparam logic CSR_AXES   = 1'b1;

   // Search tolerance in Q16.16 LSBs (about 0.1 ms).
   localparam logic [32:0] SEARCH_TOL = 33'd7;

   // Second multiplier operand: wide enough for 15!/0! and a 33-bit local time.
   localparam int MUL_B_W = 41;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]         action;
      logic [2:0]         axis;
      logic [2:0]         power;
      logic signed [63:0] coeff_value;
      logic [31:0]        duration;
      logic [31:0]        query_time;
      logic [2:0]         deriv_order;
   } cmd_type;

   // Falling factorial j!/(j-k)! for j, k in 0..15, entry j*16+k.
   function automatic logic [256*MUL_B_W-1:0] build_fall();
      logic [256*MUL_B_W-1:0] tab;
      logic [MUL_B_W-1:0]     w;
      tab = '0;
      for (int j = 0; j < 16; j++) begin
         for (int k = 0; k < 16; k++) begin
            w = MUL_B_W'(1);
            if (k <= j) begin
               for (int i = 0; i < k; i++) begin
                  w = MUL_B_W'(w * MUL_B_W'(j - i));
               end
            end
            tab[(j*16+k)*MUL_B_W +: MUL_B_W] = w;
         end
      end
      return tab;
   endfunction

   localparam logic [256*MUL_B_W-1:0] FALL_TAB = build_fall();

endpackage
`default_nettype wire

@@ hw/rtl/piecewise_poly_traj_eval.sv @@
// Top level of the piecewise polynomial trajectory evaluator: configuration
// registers, front end with command queue, and back end. Depends on ppte_pkg,
// ppte_front and ppte_back.
//
// Channel | Direction | Handshake             | Contents
// req_    | in        | req_tvalid/req_tready | tuser: action; tdata: command fields
// rsp_    | out       | rsp_tvalid/rsp_tready | tuser: status; tdata: value, axis
// csr_    | in        | csr_we                | index 0 degree, index 1 axis count
//
// A clear transaction sweeps the coefficient memory, one entry per cycle
// (1024 entries at the default sizes); the same sweep runs after reset, and
// the back end takes no command while it runs. An evaluation walks the
// segments and then runs Horner steps for each axis on the shared multiplier;
// an axis whose order k exceeds the degree d yields zero without products.
// Reset is synchronous and active high. The two-entry command queue keeps
// accepting while the back end works, and the result register holds a stalled
// result while the back end goes on to the next one.
`default_nettype none
module piecewise_poly_traj_eval import ppte_pkg::*; #(
   parameter int MAX_SEGMENTS = 16,
   parameter int MAX_DEGREE   = 7,
   parameter int MAX_AXES     = 6
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // req_tdata from bit 0: axis[2:0], power[5:3], coeff_value[69:6],
   // duration[101:70], query_time[133:102], deriv_order[136:134], zeros
   input  wire logic [143:0] req_tdata,
   // req_tuser: action[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // rsp_tdata from bit 0: value[63:0], axis_out[66:64], zeros
   output logic [71:0]       rsp_tdata,
   output logic              rsp_tlast,
   // rsp_tuser: status[1:0]
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [2:0]   csr_wdata
);

   logic [2:0] degree_ff, degree_in;
   logic [2:0] axes_ff, axes_in;
   logic       q_valid;
   logic       pop;
   cmd_type    q_cmd;

   // The user must make configuration writes only while the block is idle; the block does not enforce this.
   always_comb begin
      degree_in = degree_ff;
      axes_in   = axes_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEGREE: degree_in = csr_wdata;
            CSR_AXES:   axes_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 3'd5;
         axes_ff   <= 3'd6;
      end else begin
         degree_ff <= degree_in;
         axes_ff   <= axes_in;
      end
   end

   ppte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd)
   );

   ppte_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .MAX_DEGREE   (MAX_DEGREE),
      .MAX_AXES     (MAX_AXES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .pop         (pop),
      .poly_degree (degree_ff),
      .axis_count  (axes_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire

@@ hw/rtl/ppte_front.sv @@
// Front end: takes request transactions, splits the payload into a command
// and holds up to two commands for the back end. Depends on ppte_pkg.
`default_nettype none
module ppte_front import ppte_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [143:0]  req_tdata,
   input  wire logic [1:0]    req_tuser,
   input  wire logic          pop,
   output logic               q_valid,
   output cmd_type            q_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd;
   logic       push;

   always_comb begin
      cmd.action      = req_tuser;
      cmd.axis        = req_tdata[2:0];
      cmd.power       = req_tdata[5:3];
      cmd.coeff_value = req_tdata[69:6];
      cmd.duration    = req_tdata[101:70];
      cmd.query_time  = req_tdata[133:102];
      cmd.deriv_order = req_tdata[136:134];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_cmd      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/ppte_back.sv @@
// Back end: segment table, coefficient memory, segment search and Horner
// evaluation on a shared multi-cycle multiplier. Depends on ppte_pkg.
`default_nettype none
module ppte_back import ppte_pkg::*; #(
   parameter int MAX_SEGMENTS = 16,
   parameter int MAX_DEGREE   = 7,
   parameter int MAX_AXES     = 6
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_valid,
   input  wire cmd_type      q_cmd,
   output logic              pop,
   input  wire logic [2:0]   poly_degree,
   input  wire logic [2:0]   axis_count,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [71:0]       rsp_tdata,
   output logic              rsp_tlast,
   output logic [1:0]        rsp_tuser
);

   localparam int SGW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int AXW   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
   localparam int PWW   = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
   localparam int AW    = SGW + AXW + PWW;
   localparam int DEPTH = 1 << AW;
   localparam int DDEP  = 1 << SGW;
   localparam int CW    = $clog2(MAX_SEGMENTS + 1);
   localparam int TW    = 32 + CW;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_SRD  = 4'd2;
   localparam logic [3:0] S_SCMP = 4'd3;
   localparam logic [3:0] S_AX   = 4'd4;
   localparam logic [3:0] S_BW   = 4'd5;
   localparam logic [3:0] S_M0   = 4'd6;
   localparam logic [3:0] S_M1   = 4'd7;
   localparam logic [3:0] S_M2   = 4'd8;
   localparam logic [3:0] S_M3   = 4'd9;
   localparam logic [3:0] S_MD   = 4'd10;
   localparam logic [3:0] S_NXT  = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;

   localparam logic [1:0] PH_FIRST = 2'd0;
   localparam logic [1:0] PH_B     = 2'd1;
   localparam logic [1:0] PH_T     = 2'd2;

   logic [3:0]           state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [TW-1:0]        total_ff, total_in;
   logic [TW-1:0]        t_ff, t_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [2:0]           i_ff, i_in;
   logic [3:0]           j_ff, j_in;
   logic [3:0]           k_ff, k_in;
   logic [3:0]           d_ff, d_in;
   logic [3:0]           n_ff, n_in;
   logic [1:0]           phase_ff, phase_in;
   logic [63:0]          mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [MUL_B_W-1:0]   mb_ff, mb_in;
   logic                 sh_ff, sh_in;
   logic [MUL_B_W+31:0]  p0_ff, p0_in;
   logic [MUL_B_W+31:0]  p1_ff, p1_in;
   logic [MUL_B_W+63:0]  sum_ff, sum_in;
   logic signed [63:0]   mres_ff, mres_in;
   logic signed [63:0]   bval_ff, bval_in;
   logic signed [63:0]   acc_ff, acc_in;

   logic                 ovalid_ff, ovalid_in;
   logic signed [63:0]   ovalue_ff, ovalue_in;
   logic [2:0]           oaxis_ff, oaxis_in;
   logic                 olast_ff, olast_in;
   logic [1:0]           ostatus_ff, ostatus_in;

   logic signed [63:0]   cmem [DEPTH];
   logic signed [63:0]   cq_ff;
   logic                 cwe;
   logic [AW-1:0]        cwaddr, craddr;
   logic signed [63:0]   cwdata;
   logic [31:0]          dmem [DDEP];
   logic [31:0]          dq_ff;
   logic                 dwe;
   logic [SGW-1:0]       draddr;

   logic                 out_free;
   logic [MUL_B_W+63:0]  shifted;
   logic [63:0]          res;
   logic [63:0]          limit;
   logic signed [63:0]   ssum;
   logic [3:0]           deg4, ax4;
   logic [3:0]           inext;

   assign out_free   = !ovalid_ff || rsp_tready;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {5'b0, oaxis_ff, ovalue_ff};
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ostatus_ff;

   assign deg4  = {1'b0, poly_degree};
   assign ax4   = {1'b0, axis_count};
   assign inext = {1'b0, i_ff} + 4'd1;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cnt_in     = cnt_ff;
      total_in   = total_ff;
      t_in       = t_ff;
      idx_in     = idx_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      d_in       = d_ff;
      n_in       = n_ff;
      phase_in   = phase_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      mb_in      = mb_ff;
      sh_in      = sh_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      sum_in     = sum_ff;
      mres_in    = mres_ff;
      bval_in    = bval_ff;
      acc_in     = acc_ff;
      ovalid_in  = ovalid_ff && !rsp_tready;
      ovalue_in  = ovalue_ff;
      oaxis_in   = oaxis_ff;
      olast_in   = olast_ff;
      ostatus_in = ostatus_ff;
      pop        = 1'b0;
      cwe        = 1'b0;
      cwaddr     = clr_ff;
      cwdata     = '0;
      craddr     = '0;
      dwe        = 1'b0;
      draddr     = idx_ff[SGW-1:0];
      shifted    = sh_ff ? (sum_ff >> 16) : sum_ff;
      res        = shifted[63:0];
      limit      = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      ssum       = mres_ff + bval_ff;

      unique case (state_ff)
         S_CLR: begin
            cwe    = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.action)
                  ACT_CLEAR: begin
                     pop      = 1'b1;
                     cnt_in   = '0;
                     total_in = '0;
                     clr_in   = '0;
                     state_in = S_CLR;
                  end
                  ACT_WRITE: begin
                     pop = 1'b1;
                     if (cnt_ff < CW'(MAX_SEGMENTS) && {1'b0, q_cmd.axis} < 4'(MAX_AXES)
                         && {1'b0, q_cmd.power} <= 4'(MAX_DEGREE)) begin
                        cwe    = 1'b1;
                        cwaddr = {cnt_ff[SGW-1:0], AXW'(q_cmd.axis), PWW'(q_cmd.power)};
                        cwdata = q_cmd.coeff_value;
                     end
                  end
                  ACT_COMMIT: begin
                     if (out_free) begin
                        pop       = 1'b1;
                        ovalid_in = 1'b1;
                        ovalue_in = '0;
                        oaxis_in  = '0;
                        olast_in  = 1'b1;
                        if (cnt_ff < CW'(MAX_SEGMENTS)) begin
                           dwe        = 1'b1;
                           draddr     = cnt_ff[SGW-1:0];
                           total_in   = total_ff + TW'(q_cmd.duration);
                           cnt_in     = cnt_ff + CW'(1);
                           ostatus_in = STATUS_OK;
                        end else begin
                           ostatus_in = STATUS_FULL;
                        end
                     end
                  end
                  ACT_EVAL: begin
                     if (cnt_ff == '0) begin
                        if (out_free) begin
                           pop        = 1'b1;
                           ovalid_in  = 1'b1;
                           ovalue_in  = '0;
                           oaxis_in   = '0;
                           olast_in   = 1'b1;
                           ostatus_in = STATUS_EMPTY;
                        end
                     end else begin
                        pop    = 1'b1;
                        t_in   = (TW'(q_cmd.query_time) > total_ff) ? total_ff
                                                               : TW'(q_cmd.query_time);
                        idx_in = '0;
                        i_in   = '0;
                        k_in   = {1'b0, q_cmd.deriv_order};
                        d_in   = (deg4 > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE) : deg4;
                        n_in   = (ax4 == 4'd0) ? 4'd1
                               : ((ax4 > 4'(MAX_AXES)) ? 4'(MAX_AXES) : ax4);
                        state_in = S_SRD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SRD: begin
            draddr = idx_ff[SGW-1:0];
            if ({1'b0, idx_ff} + (CW+1)'(1) < {1'b0, cnt_ff}) begin
               state_in = S_SCMP;
            end else begin
               state_in = S_AX;
            end
         end
         S_SCMP: begin
            if (TW'(dq_ff) + TW'(SEARCH_TOL) < t_ff) begin
               t_in     = t_ff - TW'(dq_ff);
               idx_in   = idx_ff + CW'(1);
               state_in = S_SRD;
            end else begin
               state_in = S_AX;
            end
         end
         S_AX: begin
            if (k_ff > d_ff) begin
               acc_in   = '0;
               state_in = S_OUT;
            end else begin
               j_in     = d_ff;
               phase_in = PH_FIRST;
               craddr   = {idx_ff[SGW-1:0], AXW'(i_ff), PWW'(d_ff)};
               state_in = S_BW;
            end
         end
         S_BW: begin
            neg_in   = cq_ff[63];
            mag_in   = cq_ff[63] ? 64'(-cq_ff) : 64'(cq_ff);
            mb_in    = FALL_TAB[int'({j_ff, k_ff}) * MUL_B_W +: MUL_B_W];
            sh_in    = 1'b0;
            state_in = S_M0;
         end
         S_M0: begin
            p0_in    = (MUL_B_W+32)'(mag_ff[31:0] * mb_ff);
            state_in = S_M1;
         end
         S_M1: begin
            p1_in    = (MUL_B_W+32)'(mag_ff[63:32] * mb_ff);
            state_in = S_M2;
         end
         S_M2: begin
            // Partial products joined; half an LSB added when 16 bits are dropped.
            sum_in = {32'b0, p0_ff} + {p1_ff, 32'b0}
                   + (sh_ff ? (MUL_B_W+64)'(32768) : '0);
            state_in = S_M3;
         end
         S_M3: begin
            if ((|shifted[MUL_B_W+63:64]) || res > limit) begin
               res = limit;
            end
            mres_in  = neg_ff ? -$signed(res) : $signed(res);
            state_in = S_MD;
         end
         S_MD: begin
            unique case (phase_ff)
               PH_FIRST: begin
                  acc_in   = mres_ff;
                  state_in = S_NXT;
               end
               PH_B: begin
                  bval_in  = mres_ff;
                  neg_in   = acc_ff[63];
                  mag_in   = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
                  mb_in    = MUL_B_W'(t_ff[32:0]);
                  sh_in    = 1'b1;
                  phase_in = PH_T;
                  state_in = S_M0;
               end
               PH_T: begin
                  if (mres_ff[63] == bval_ff[63] && ssum[63] != mres_ff[63]) begin
                     acc_in = mres_ff[63] ? S64_MIN : S64_MAX;
                  end else begin
                     acc_in = ssum;
                  end
                  state_in = S_NXT;
               end
               default: state_in = S_NXT;
            endcase
         end
         S_NXT: begin
            if (j_ff > k_ff) begin
               j_in     = j_ff - 4'd1;
               craddr   = {idx_ff[SGW-1:0], AXW'(i_ff), PWW'(j_ff - 4'd1)};
               phase_in = PH_B;
               state_in = S_BW;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               ovalid_in  = 1'b1;
               ovalue_in  = acc_ff;
               oaxis_in   = i_ff;
               olast_in   = (inext == n_ff);
               ostatus_in = STATUS_OK;
               if (inext == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 3'd1;
                  state_in = S_AX;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         clr_ff    <= '0;
         cnt_ff    <= '0;
         total_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         cnt_ff    <= cnt_in;
         total_ff  <= total_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff       <= t_in;
      idx_ff     <= idx_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      d_ff       <= d_in;
      n_ff       <= n_in;
      phase_ff   <= phase_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      mb_ff      <= mb_in;
      sh_ff      <= sh_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      sum_ff     <= sum_in;
      mres_ff    <= mres_in;
      bval_ff    <= bval_in;
      acc_ff     <= acc_in;
      ovalue_ff  <= ovalue_in;
      oaxis_ff   <= oaxis_in;
      olast_ff   <= olast_in;
      ostatus_ff <= ostatus_in;
   end

   always_ff @(posedge clock) begin
      if (cwe) begin
         cmem[cwaddr] <= cwdata;
      end
      cq_ff <= cmem[craddr];
   end

   always_ff @(posedge clock) begin
      if (dwe) begin
         dmem[draddr] <= q_cmd.duration;
      end
      dq_ff <= dmem[draddr];
   end

endmodule
`default_nettype wire

@@ hw/rtl/ppte_checker.sv @@
// Port-level checks for the trajectory evaluator, bound to the top level.
// Depends on ppte_pkg and piecewise_poly_traj_eval.
`default_nettype none
module ppte_checker import ppte_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [143:0] req_tdata,
   input wire logic [1:0]   req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [71:0]  rsp_tdata,
   input wire logic         rsp_tlast,
   input wire logic [1:0]   rsp_tuser
);

   // No result is shown in the cycle after reset.
   a_rsp_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The command queue is empty, so ready, right after reset.
   a_req_ready_after_reset: assert property (@(posedge clock) reset |=> req_tready)
      else $error("request not ready after reset");

   // Results with a status other than OK (full or empty table) are single, zero-valued transactions.
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("status result not a single zero transaction");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // A request that waits for acceptance stays offered and unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata)
                                       && $stable(req_tuser)))
      else $error("waiting request changed");

endmodule

bind piecewise_poly_traj_eval ppte_checker u_ppte_checker (.*);
`default_nettype wire
